// File: design/spc_pkg.sv
package spc_pkg;

  // Fixed field widths
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned DLIM_W     = 8;
  localparam int unsigned TGT_W      = 16;
  localparam int unsigned MEAS_W     = 20;
  localparam int unsigned ERR_W      = 21;
  localparam int unsigned INTEG_W    = 34;
  localparam int unsigned ACC_W      = 38;
  localparam int unsigned MUL_A_W    = 34;
  localparam int unsigned MUL_B_W    = 17;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned SUM_W      = 54;
  localparam int unsigned FRAC_SHIFT = 36;
  localparam int unsigned VAL_W      = SUM_W - FRAC_SHIFT;
  localparam int unsigned DUTY_MAX_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_SAMPLE_PERIOD = 3'd2,
    REG_INTEG_LIMIT   = 3'd3,
    REG_DUTY_FLOOR    = 3'd4,
    REG_DUTY_CEILING  = 3'd5
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST     = 16'd328;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST    = 16'd3015;
  localparam logic [GAIN_W-1:0]  SAMPLE_PERIOD_RST = 16'd1311;
  localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST   = 16'd5000;
  localparam logic [DLIM_W-1:0]  DUTY_FLOOR_RST    = 8'd0;
  localparam logic [DLIM_W-1:0]  DUTY_CEILING_RST  = 8'd250;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [GAIN_W-1:0]  sample_period;
    logic [LIMIT_W-1:0] integ_limit;
    logic [DLIM_W-1:0]  duty_floor;
    logic [DLIM_W-1:0]  duty_ceiling;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture input transaction, form error
    logic mul_err;   // product <= error * sample_period
    logic integ;     // update clamped integral; product <= prop_gain * error
    logic pterm;     // sum <= proportional term; product <= integ_gain * integral
    logic add;       // sum <= sum + product
    logic fin;       // truncate, clamp, write output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic active;    // captured tick is a running tick
    logic out_full;  // output register holds an unaccepted result
  } dp_stat_t;

endpackage

// File: design/motor_speed_pi_controller.sv
// Fixed-point PI motor speed controller with a clamped integral. Each input
// transaction is one control tick: run flag, target speed in whole rpm and
// an optional measured speed (Q16.4 rpm). A tick with the run inactive or a
// target of zero or below clears the integral and gives a raw duty of 0;
// otherwise error = target - measured is integrated with the sample period
// (integral clamped to +/- integ_limit rpm-seconds) and the duty is
// prop_gain*error + integ_gain*integral, truncated toward zero and clamped
// to [duty_floor, duty_ceiling] (floor test first). Each tick yields one
// result transaction with the duty and a flag that is set when it differs
// from the previous duty (always set on the first tick after reset).
// Timing: one tick at a time; the sequencer uses the single shared 34x17
// multiplier three times per running tick and once per idle tick. A
// finished result waits in the output register while the next tick is
// accepted. Gains and period are unsigned Q0.16. Write configuration
// registers only while no tick is in flight; unknown register indexes are
// dropped.
module motor_speed_pi_controller
  import spc_pkg::*;
#(
  parameter int unsigned DUTY_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // tick input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_run_active,
  input  logic [TGT_W-1:0]      in_target_speed,
  input  logic                  in_speed_valid,
  input  logic [MEAS_W-1:0]     in_measured_speed,
  // duty result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DUTY_WIDTH-1:0] out_duty,
  output logic                  out_duty_changed
);

  cfg_t     cfg_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration registers: write on enable, drop unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain     <= PROP_GAIN_RST;
      cfg_r.integ_gain    <= INTEG_GAIN_RST;
      cfg_r.sample_period <= SAMPLE_PERIOD_RST;
      cfg_r.integ_limit   <= INTEG_LIMIT_RST;
      cfg_r.duty_floor    <= DUTY_FLOOR_RST;
      cfg_r.duty_ceiling  <= DUTY_CEILING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:     cfg_r.prop_gain     <= cfg_wdata;
        REG_INTEG_GAIN:    cfg_r.integ_gain    <= cfg_wdata;
        REG_SAMPLE_PERIOD: cfg_r.sample_period <= cfg_wdata;
        REG_INTEG_LIMIT:   cfg_r.integ_limit   <= cfg_wdata;
        REG_DUTY_FLOOR:    cfg_r.duty_floor    <= cfg_wdata[DLIM_W-1:0];
        REG_DUTY_CEILING:  cfg_r.duty_ceiling  <= cfg_wdata[DLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: advance one step of the tick per cycle, holding in FIN while the output register is full
  spc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic, integral state and output register
  spc_dp #(
    .DUTY_WIDTH (DUTY_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .cmd               (cmd),
    .stat              (stat),
    .in_run_active     (in_run_active),
    .in_target_speed   (in_target_speed),
    .in_speed_valid    (in_speed_valid),
    .in_measured_speed (in_measured_speed),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_duty          (out_duty),
    .out_duty_changed  (out_duty_changed)
  );

endmodule

// File: design/spc_dp.sv
module spc_dp
  import spc_pkg::*;
#(
  parameter int unsigned DUTY_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  in_run_active,
  input  logic [TGT_W-1:0]      in_target_speed,
  input  logic                  in_speed_valid,
  input  logic [MEAS_W-1:0]     in_measured_speed,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DUTY_WIDTH-1:0] out_duty,
  output logic                  out_duty_changed
);

  logic                      active_r;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic                      out_valid_r;
  logic [DUTY_WIDTH-1:0]     duty_r;
  logic                      changed_r;
  logic [DUTY_WIDTH-1:0]     last_duty_r;
  logic                      last_valid_r;

  logic                      in_active;
  logic signed [ERR_W-1:0]   err_in;
  logic [MEAS_W-1:0]         meas_eff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [GAIN_W-1:0]         mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic [INTEG_W-1:0]        bound;
  logic signed [ACC_W-1:0]   acc, bound_pos, bound_neg;
  logic signed [SUM_W-1:0]   adj;
  logic signed [VAL_W-1:0]   value;
  logic [DLIM_W-1:0]         clamp_v;
  logic [DUTY_MAX_W-1:0]     clamp_wide;
  logic [DUTY_WIDTH-1:0]     duty_nxt;

  // Error: target (Q.4) minus measured; zero on idle ticks
  always_comb begin
    in_active = in_run_active && !in_target_speed[TGT_W-1] && (in_target_speed != '0);
    meas_eff  = in_speed_valid ? in_measured_speed : '0;
    err_in    = $signed({2'b00, in_target_speed[TGT_W-2:0], 4'b0000})
              - $signed({1'b0, meas_eff});
  end

  // Shared multiplier: signed A by unsigned 16-bit gain
  always_comb begin
    if (cmd.pterm) begin
      mul_a = integ_r;
      mul_b = cfg.integ_gain;
    end else begin
      mul_a = MUL_A_W'(err_r);
      mul_b = cmd.integ ? cfg.prop_gain : cfg.sample_period;
    end
    mul_p = mul_a * $signed({1'b0, mul_b});
  end

  // Integral clamp: limit * 2^20, saturated to the 34-bit signed range
  always_comb begin
    if (cfg.integ_limit[LIMIT_W-1:13] != '0) begin
      bound = {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      bound = {1'b0, cfg.integ_limit[12:0], 20'd0};
    end
    bound_pos = $signed({{(ACC_W-INTEG_W){1'b0}}, bound});
    bound_neg = -bound_pos;
    acc = ACC_W'(integ_r) + prod_r[ACC_W-1:0];
    if (acc > bound_pos) begin
      integ_nxt = bound_pos[INTEG_W-1:0];
    end else if (acc < bound_neg) begin
      integ_nxt = bound_neg[INTEG_W-1:0];
    end else begin
      integ_nxt = acc[INTEG_W-1:0];
    end
  end

  // Truncate toward zero, then clamp to floor/ceiling (floor test first)
  always_comb begin
    adj = sum_r + (sum_r[SUM_W-1] ? SUM_W'((64'd1 << FRAC_SHIFT) - 64'd1) : '0);
    value = active_r ? adj[SUM_W-1:FRAC_SHIFT] : '0;
    if (value < $signed({{(VAL_W-DLIM_W){1'b0}}, cfg.duty_floor})) begin
      clamp_v = cfg.duty_floor;
    end else if (value > $signed({{(VAL_W-DLIM_W){1'b0}}, cfg.duty_ceiling})) begin
      clamp_v = cfg.duty_ceiling;
    end else begin
      clamp_v = value[DLIM_W-1:0];
    end
    clamp_wide = {{(DUTY_MAX_W-DLIM_W){1'b0}}, clamp_v};
    duty_nxt   = clamp_wide[DUTY_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      active_r <= in_active;
      err_r    <= in_active ? err_in : '0;
    end
    if (cmd.mul_err || cmd.integ || cmd.pterm) begin
      prod_r <= mul_p;
    end
    if (cmd.pterm) begin
      sum_r <= {prod_r[ACC_W-1:0], 16'd0};
    end else if (cmd.add) begin
      sum_r <= sum_r + SUM_W'(prod_r);
    end
    if (cmd.fin) begin
      duty_r    <= duty_nxt;
      changed_r <= !last_valid_r || (duty_nxt != last_duty_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r      <= '0;
      last_duty_r  <= '0;
      last_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load && !in_active) begin
        integ_r <= '0;
      end else if (cmd.integ) begin
        integ_r <= integ_nxt;
      end
      if (cmd.fin) begin
        last_duty_r  <= duty_nxt;
        last_valid_r <= 1'b1;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.active      = active_r;
  assign stat.out_full    = out_valid_r && !out_ready;
  assign out_valid        = out_valid_r;
  assign out_duty         = duty_r;
  assign out_duty_changed = changed_r;

endmodule

// File: design/spc_ctrl.sv
module spc_ctrl
  import spc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_MUL_ERR = 6'b000010,
    S_INTEG   = 6'b000100,
    S_PTERM   = 6'b001000,
    S_ADD     = 6'b010000,
    S_FIN     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // hold off the input channel while reset is asserted
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL_ERR;
        end
      end
      S_MUL_ERR: begin
        cmd.mul_err = 1'b1;
        state_nxt   = stat.active ? S_INTEG : S_FIN;
      end
      S_INTEG: begin
        cmd.integ = 1'b1;
        state_nxt = S_PTERM;
      end
      S_PTERM: begin
        cmd.pterm = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register frees up
        if (!stat.out_full) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: test/motor_speed_pi_controller_tb.sv
module motor_speed_pi_controller_tb
  import spc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DUTY_W         = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Allowance for the longest tick, with a little margin on top
  localparam int unsigned SETTLE_CYCLES  = 10;
  // Integral saturates at the top of the 34-bit signed range
  localparam longint      INTEG_SAT      = 64'sd8589934591;
  // Indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct {
    logic                    run;
    logic signed [TGT_W-1:0] target;
    logic                    spd_valid;
    logic [MEAS_W-1:0]       meas;
  } tick_t;

  typedef struct {
    logic [DUTY_W-1:0] duty;
    logic              changed;
  } duty_res_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_run_active;
  logic [TGT_W-1:0]      in_target_speed;
  logic                  in_speed_valid;
  logic [MEAS_W-1:0]     in_measured_speed;
  logic                  out_valid;
  logic                  out_ready;
  logic [DUTY_W-1:0]     out_duty;
  logic                  out_duty_changed;

  // Controller copy: registers and state, tracked alongside the block
  logic [GAIN_W-1:0]  pi_prop_gain;
  logic [GAIN_W-1:0]  pi_integ_gain;
  logic [GAIN_W-1:0]  pi_sample_period;
  logic [LIMIT_W-1:0] pi_integ_limit;
  logic [DLIM_W-1:0]  pi_duty_floor;
  logic [DLIM_W-1:0]  pi_duty_ceiling;
  longint             pi_integral;
  logic [DUTY_W-1:0]  pi_last_duty;
  bit                 pi_last_valid;

  duty_res_t          expected_duties[$];
  duty_res_t          seen_duty;
  int                 fail_count  = 0;
  int                 quiet_cycles = 0;
  int                 stall_left;
  bit                 tx_idle;
  bit                 rx_idle;
  // Target held across a run of well-formed ticks so the integral builds up
  logic signed [TGT_W-1:0] hold_target;

  motor_speed_pi_controller #(
    .DUTY_WIDTH(DUTY_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_run_active     (in_run_active),
    .in_target_speed   (in_target_speed),
    .in_speed_valid    (in_speed_valid),
    .in_measured_speed (in_measured_speed),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_duty          (out_duty),
    .out_duty_changed  (out_duty_changed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advance the controller copy by one tick and return the duty it issues
  function automatic duty_res_t next_duty(input tick_t t);
    duty_res_t res;
    longint    tgt;
    longint    meas;
    longint    err;
    longint    bound;
    longint    acc;
    longint    sum;
    longint    mag;
    longint    val;
    // Inactive run or non-positive target counts as a zero target
    tgt  = (t.run && t.target > 0) ? longint'(t.target) : 64'sd0;
    // A missing measurement reads as zero speed
    meas = t.spd_valid ? longint'(t.meas) : 64'sd0;
    if (tgt > 0) begin
      err   = tgt * 16 - meas;
      bound = longint'(pi_integ_limit) * 1048576;
      if (bound > INTEG_SAT) bound = INTEG_SAT;
      acc = pi_integral + err * longint'(pi_sample_period);
      if (acc > bound) acc = bound;
      else if (acc < -bound) acc = -bound;
      pi_integral = acc;
      sum = longint'(pi_prop_gain) * err * 65536 + longint'(pi_integ_gain) * acc;
      // Truncate toward zero: shift the magnitude, then restore the sign
      mag = (sum < 0) ? -sum : sum;
      mag = mag >>> 36;
      val = (sum < 0) ? -mag : mag;
    end else begin
      pi_integral = 0;
      val = 0;
    end
    // Floor test wins when floor sits above ceiling
    if (val < longint'(pi_duty_floor)) val = longint'(pi_duty_floor);
    else if (val > longint'(pi_duty_ceiling)) val = longint'(pi_duty_ceiling);
    res.duty      = val[DUTY_W-1:0];
    res.changed   = !pi_last_valid || (res.duty != pi_last_duty);
    pi_last_duty  = res.duty;
    pi_last_valid = 1'b1;
    return res;
  endfunction

  function automatic tick_t mk_tick(input logic run, input logic signed [TGT_W-1:0] target,
                                    input logic spd_valid, input logic [MEAS_W-1:0] meas);
    tick_t t;
    t.run       = run;
    t.target    = target;
    t.spd_valid = spd_valid;
    t.meas      = meas;
    return t;
  endfunction

  // Mostly well-formed tracking ticks around a held target, the rest noise,
  // idle ticks and field extremes
  function automatic tick_t rand_tick();
    tick_t  t;
    int     r;
    longint m;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) hold_target = TGT_W'($urandom_range(1, 32767));
    t.run       = 1'b1;
    t.spd_valid = 1'b1;
    if (r < 65) begin
      t.target    = hold_target;
      t.spd_valid = ($urandom_range(0, 19) != 0);
      m = longint'(hold_target) * 16 + longint'($urandom_range(0, 4000)) - 2000;
      if (m < 0) m = 0;
      if (m > 64'sd1048575) m = 64'sd1048575;
      t.meas = m[MEAS_W-1:0];
    end else if (r < 80) begin
      t.run       = 1'($urandom_range(0, 1));
      t.target    = TGT_W'($urandom);
      t.spd_valid = 1'($urandom_range(0, 1));
      t.meas      = MEAS_W'($urandom);
    end else if (r < 90) begin
      t.run       = 1'($urandom_range(0, 1));
      t.target    = ($urandom_range(0, 3) == 0) ? '0 : {1'b1, 15'($urandom)};
      if (!t.run) t.target = TGT_W'($urandom);
      t.spd_valid = 1'($urandom_range(0, 1));
      t.meas      = MEAS_W'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0: t.target = 16'sh7FFF;
        1: t.target = 16'sh8000;
        2: t.target = 16'sd1;
        default: t.target = '0;
      endcase
      t.run       = ($urandom_range(0, 4) != 0);
      t.spd_valid = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 2))
        0: t.meas = '0;
        1: t.meas = '1;
        default: t.meas = MEAS_W'($urandom);
      endcase
    end
    return t;
  endfunction

  // Offer one tick, hold it until accepted, then queue its expected duty
  task automatic send_tick(input tick_t t);
    int gap;
    gap = tx_idle ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid        <= 1'b0;
      in_target_speed <= TGT_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_run_active     <= t.run;
    in_target_speed   <= t.target;
    in_speed_valid    <= t.spd_valid;
    in_measured_speed <= t.meas;
    do @(posedge clk); while (!in_ready);
    expected_duties.push_back(next_duty(t));
  endtask

  task automatic run_ticks(input int count);
    repeat (count) send_tick(rand_tick());
  endtask

  // Drop valid and wait until every queued duty has come back
  task automatic drain_results(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller drops it after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_PROP_GAIN:     pi_prop_gain     = val;
      REG_INTEG_GAIN:    pi_integ_gain    = val;
      REG_SAMPLE_PERIOD: pi_sample_period = val;
      REG_INTEG_LIMIT:   pi_integ_limit   = val;
      REG_DUTY_FLOOR:    pi_duty_floor    = val[DLIM_W-1:0];
      REG_DUTY_CEILING:  pi_duty_ceiling  = val[DLIM_W-1:0];
      default: ;
    endcase
  endtask

  // Reprogram all six registers once the block has gone quiet; the 8-bit
  // registers get junk in the upper data bits, which must be ignored
  task automatic write_settings(input logic [15:0] pg, input logic [15:0] ig,
                                input logic [15:0] sp, input logic [15:0] lim,
                                input logic [7:0] fl, input logic [7:0] ce);
    drain_results(SETTLE_CYCLES);
    write_reg(REG_PROP_GAIN, pg);
    write_reg(REG_INTEG_GAIN, ig);
    write_reg(REG_SAMPLE_PERIOD, sp);
    write_reg(REG_INTEG_LIMIT, lim);
    write_reg(REG_DUTY_FLOOR, {8'($urandom), fl});
    write_reg(REG_DUTY_CEILING, {8'($urandom), ce});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reset values, first-tick change flag and the extremes of each field
  task automatic test_startup_ticks();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_tick(mk_tick(1'b0, 16'sd0, 1'b0, 20'd0));
    send_tick(mk_tick(1'b1, 16'sh7FFF, 1'b1, 20'd0));
    send_tick(mk_tick(1'b1, 16'sh7FFF, 1'b0, 20'hFFFFF));
    send_tick(mk_tick(1'b1, 16'sd1, 1'b1, 20'hFFFFF));
    send_tick(mk_tick(1'b1, 16'sh8000, 1'b1, 20'd0));
    send_tick(mk_tick(1'b0, 16'sh7FFF, 1'b1, 20'd0));
    send_tick(mk_tick(1'b1, 16'sd0, 1'b1, 20'd100));
    send_tick(mk_tick(1'b1, 16'sd1, 1'b1, 20'd16));
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_tick(mk_tick(1'b1, 16'sh7FFF, 1'b1, 20'hFFFFF));
    send_tick(mk_tick(1'b1, 16'sd100, 1'b1, 20'd1500));
    send_tick(mk_tick(1'b1, 16'sh7FFF, 1'b1, 20'd524272));
    send_tick(mk_tick(1'b1, -16'sd1, 1'b1, 20'd0));
    send_tick(mk_tick(1'b1, 16'sd2000, 1'b0, 20'h5A5A5));
  endtask

  // Zero and full-scale registers, floor above ceiling, raised floor on idle ticks
  task automatic test_register_extremes();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    write_settings(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
    run_ticks(30);
    write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    run_ticks(30);
    write_settings(PROP_GAIN_RST, INTEG_GAIN_RST, SAMPLE_PERIOD_RST, INTEG_LIMIT_RST,
                   8'd200, 8'd50);
    run_ticks(30);
    write_settings(PROP_GAIN_RST, INTEG_GAIN_RST, SAMPLE_PERIOD_RST, INTEG_LIMIT_RST,
                   8'd40, 8'd220);
    send_tick(mk_tick(1'b0, 16'sh7FFF, 1'b1, 20'd0));
    send_tick(mk_tick(1'b1, 16'sd0, 1'b1, 20'd0));
    run_ticks(25);
    write_settings(16'd500, 16'hFFFF, 16'hFFFF, 16'd1, 8'd0, 8'hFF);
    run_ticks(30);
    write_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0, 8'hFF);
    run_ticks(30);
  endtask

  // Writes past the last register must leave the settings untouched
  task automatic test_unmapped_index();
    drain_results(SETTLE_CYCLES);
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    run_ticks(20);
  endtask

  // Drive the integral into both clamp rails, then into the saturated bound
  task automatic test_integral_clamp();
    write_settings(16'd100, 16'd20000, 16'hFFFF, 16'd3, 8'd0, 8'hFF);
    repeat (30) send_tick(mk_tick(1'b1, 16'sd500, 1'b1, 20'd0));
    repeat (30) send_tick(mk_tick(1'b1, 16'sd500, 1'b1, 20'd12000));
    write_settings(16'd50, 16'd40000, 16'd30000, 16'hFFFF, 8'd10, 8'd240);
    repeat (10) send_tick(mk_tick(1'b1, 16'sh7FFF, 1'b1, 20'd0));
    repeat (10) send_tick(mk_tick(1'b1, 16'sd1, 1'b1, 20'hFFFFF));
  endtask

  // Random settings per phase; some phases run without any idling
  task automatic test_random_settings();
    logic [15:0] pg;
    logic [15:0] ig;
    logic [15:0] sp;
    logic [15:0] lim;
    logic [7:0]  fl;
    logic [7:0]  ce;
    repeat (6) begin
      pg  = 16'($urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom_range(0, 65535));
      ig  = 16'($urandom_range(0, 1) ? $urandom_range(0, 8000) : $urandom_range(0, 65535));
      sp  = 16'($urandom_range(0, 65535));
      lim = 16'($urandom_range(0, 1) ? $urandom_range(0, 200) : $urandom_range(0, 65535));
      fl  = 8'($urandom_range(0, 60));
      ce  = 8'($urandom_range(100, 255));
      if ($urandom_range(0, 5) == 0) begin
        fl = 8'($urandom_range(0, 255));
        ce = 8'($urandom_range(0, 255));
      end
      write_settings(pg, ig, sp, lim, fl, ce);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      run_ticks(140);
    end
  endtask

  // Hold off the sender after each tick until its duty is back
  task automatic test_drained_ticks();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (30) begin
      send_tick(rand_tick());
      drain_results(0);
    end
  endtask

  // Result side: randomly stall, with stretches of steady ready
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (rx_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Compare each accepted duty transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_duties.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected duty transaction, duty %0d changed %0b",
                 $time, out_duty, out_duty_changed);
      end else begin
        seen_duty = expected_duties.pop_front();
        if (out_duty !== seen_duty.duty) begin
          fail_count++;
          $display("%0t: duty mismatch, expected %0d actual %0d",
                   $time, seen_duty.duty, out_duty);
        end
        if (out_duty_changed !== seen_duty.changed) begin
          fail_count++;
          $display("%0t: duty_changed mismatch, expected %0b actual %0b",
                   $time, seen_duty.changed, out_duty_changed);
        end
      end
    end
  end

  // Watchdog: give up when no transaction moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("motor_speed_pi_controller verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_PROP_GAIN;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_run_active     = 1'b0;
    in_target_speed   = '0;
    in_speed_valid    = 1'b0;
    in_measured_speed = '0;
    tx_idle           = 1'b0;
    rx_idle           = 1'b0;
    hold_target       = 16'sd1000;
    pi_prop_gain      = PROP_GAIN_RST;
    pi_integ_gain     = INTEG_GAIN_RST;
    pi_sample_period  = SAMPLE_PERIOD_RST;
    pi_integ_limit    = INTEG_LIMIT_RST;
    pi_duty_floor     = DUTY_FLOOR_RST;
    pi_duty_ceiling   = DUTY_CEILING_RST;
    pi_integral       = 0;
    pi_last_duty      = '0;
    pi_last_valid     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_startup_ticks();
    test_register_extremes();
    test_unmapped_index();
    test_integral_clamp();
    test_random_settings();
    test_drained_ticks();
    drain_results(SETTLE_CYCLES);

    if (fail_count == 0) begin
      $display("motor_speed_pi_controller verification clean");
    end else begin
      $display("motor_speed_pi_controller verification failed");
    end
    $finish;
  end

endmodule
